// ----- hdl/adbq_pkg.sv -----
// adbq_pkg: shared types and codes for the audio DMA buffer queue.
// No dependencies; used by adbq_front, adbq_back and audio_dma_buffer_queue.
package adbq_pkg;

    localparam int QUEUE_DEPTH = 2;   // default buffer queue depth
    localparam int FIFO_DEPTH  = 2;   // command queue between front and back
    localparam int FIFO_PW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic CMD_DRAIN = 1'b1;

    // classified operations
    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_REFUSE = 2'd1;
    localparam logic [1:0] OP_DRAIN  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_SEG = 2'd1;
    localparam logic [1:0] KIND_SUM = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [23:0] addr;
        logic [17:0] bytes;
        logic [15:0] frames;
    } t_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [23:0] seg_addr;
        logic [15:0] seg_frames;
        logic [15:0] frames_written;
        logic [15:0] silence_frames;
        logic [18:0] outstanding_bytes;
        logic        status_full;
        logic        status_busy;
        logic [47:0] frames_played;
        logic [47:0] frames_dropped;
        logic        last;
    } t_result;

endpackage

// ----- hdl/adbq_front.sv -----
// adbq_front: takes command words, classifies them and queues them for the back end.
// Depends on adbq_pkg.
module adbq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [23:0]        i_buf_addr,
    input  logic [17:0]        i_buf_bytes,
    input  logic               i_addr_ok,
    input  logic [15:0]        i_frames_requested,
    output logic               o_op_valid,
    output adbq_pkg::t_op      o_op,
    input  logic               i_op_pop
);

    adbq_pkg::t_op                   r_mem [adbq_pkg::FIFO_DEPTH];
    logic [adbq_pkg::FIFO_PW-1:0]    r_wr_ptr;
    logic [adbq_pkg::FIFO_PW-1:0]    r_rd_ptr;
    logic [adbq_pkg::FIFO_CW-1:0]    r_count;
    adbq_pkg::t_op                   w_op;
    logic                            w_push;
    logic                            w_pop;

    function automatic logic [adbq_pkg::FIFO_PW-1:0] f_inc(
        input logic [adbq_pkg::FIFO_PW-1:0] p
    );
        if (p == adbq_pkg::FIFO_PW'(adbq_pkg::FIFO_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    // classify: drain, or enqueue that is refused on a bad address up front
    always_comb begin
        w_op.addr   = i_buf_addr;
        w_op.bytes  = i_buf_bytes;
        w_op.frames = i_frames_requested;
        if (i_cmd == adbq_pkg::CMD_DRAIN) begin
            w_op.op = adbq_pkg::OP_DRAIN;
        end else if (i_addr_ok) begin
            w_op.op = adbq_pkg::OP_ENQ;
        end else begin
            w_op.op = adbq_pkg::OP_REFUSE;
        end
    end

    assign o_ready    = (r_count != adbq_pkg::FIFO_CW'(adbq_pkg::FIFO_DEPTH));
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_mem[r_rd_ptr];
    assign w_push     = i_valid && o_ready;
    assign w_pop      = i_op_pop && o_op_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= f_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= f_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/adbq_back.sv -----
// adbq_back: buffer queue state, drain sequencer and registered result word.
// Depends on adbq_pkg.
module adbq_back #(
    parameter int QUEUE_DEPTH = adbq_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    input  adbq_pkg::t_op      i_op,
    output logic               o_op_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output adbq_pkg::t_result  o_res
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CALC  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_SUM   = 2'd3;

    logic [23:0] r_addr [QUEUE_DEPTH];
    logic [17:0] r_bytes[QUEUE_DEPTH];
    logic [17:0] r_cons [QUEUE_DEPTH];
    logic [23:0] n_addr [QUEUE_DEPTH];
    logic [17:0] n_bytes[QUEUE_DEPTH];
    logic [17:0] n_cons [QUEUE_DEPTH];

    logic [CW-1:0] r_count,   n_count;
    logic [18:0]   r_outst,   n_outst;
    logic [47:0]   r_played,  n_played;
    logic [47:0]   r_dropped, n_dropped;
    logic [1:0]    r_state,   n_state;
    logic [15:0]   r_frames,  n_frames;
    logic [15:0]   r_written, n_written;
    logic [15:0]   r_n,       n_n;
    logic          r_pop,     n_pop;
    logic [1:0]    r_rem_lo,  n_rem_lo;
    logic          r_out_valid, n_out_valid;
    adbq_pkg::t_result r_out, n_out;

    logic        w_slot_free;
    logic        w_emit;
    logic [17:0] w_rem;
    logic [15:0] w_rframes;
    logic [15:0] w_need;

    assign w_slot_free = !r_out_valid || i_ready;
    assign w_rem       = r_bytes[0] - r_cons[0];
    assign w_rframes   = w_rem[17:2];
    assign w_need      = r_frames - r_written;

    always_comb begin
        n_addr      = r_addr;
        n_bytes     = r_bytes;
        n_cons      = r_cons;
        n_count     = r_count;
        n_outst     = r_outst;
        n_played    = r_played;
        n_dropped   = r_dropped;
        n_state     = r_state;
        n_frames    = r_frames;
        n_written   = r_written;
        n_n         = r_n;
        n_pop       = r_pop;
        n_rem_lo    = r_rem_lo;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_op_pop    = 1'b0;
        w_emit      = 1'b0;
        n_out.kind           = adbq_pkg::KIND_ENQ;
        n_out.accepted       = 1'b0;
        n_out.seg_addr       = '0;
        n_out.seg_frames     = '0;
        n_out.frames_written = '0;
        n_out.silence_frames = '0;
        n_out.last           = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_op_valid && w_slot_free) begin
                    o_op_pop = 1'b1;
                    case (i_op.op)
                        adbq_pkg::OP_ENQ: begin
                            w_emit = 1'b1;
                            if (r_count != CW'(QUEUE_DEPTH)) begin
                                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                                    if (r_count == CW'(i)) begin
                                        n_addr[i]  = i_op.addr;
                                        n_bytes[i] = i_op.bytes;
                                        n_cons[i]  = '0;
                                    end
                                end
                                n_count        = r_count + 1'b1;
                                n_outst        = r_outst + {1'b0, i_op.bytes};
                                n_out.accepted = 1'b1;
                            end
                        end
                        adbq_pkg::OP_REFUSE: begin
                            w_emit = 1'b1;
                        end
                        adbq_pkg::OP_DRAIN: begin
                            n_frames  = i_op.frames;
                            n_written = '0;
                            n_state   = S_CALC;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CALC: begin
                if (r_written == r_frames || r_count == '0) begin
                    n_state = S_SUM;
                end else begin
                    n_n      = (w_rframes < w_need) ? w_rframes : w_need;
                    n_pop    = (w_rframes == '0);
                    n_rem_lo = w_rem[1:0];
                    n_state  = S_APPLY;
                end
            end
            S_APPLY: begin
                if (r_pop) begin
                    // short head buffer: drop it and its leftover bytes
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        n_addr[i]  = r_addr[i + 1];
                        n_bytes[i] = r_bytes[i + 1];
                        n_cons[i]  = r_cons[i + 1];
                    end
                    n_count = r_count - 1'b1;
                    n_outst = r_outst - {17'd0, r_rem_lo};
                    n_state = S_CALC;
                end else if (w_slot_free) begin
                    w_emit               = 1'b1;
                    n_out.kind           = adbq_pkg::KIND_SEG;
                    n_out.last           = 1'b0;
                    n_out.seg_addr       = r_addr[0] + {6'd0, r_cons[0]};
                    n_out.seg_frames     = r_n;
                    n_cons[0]            = r_cons[0] + {r_n, 2'b00};
                    n_written            = r_written + r_n;
                    n_played             = r_played + {32'd0, r_n};
                    n_outst              = r_outst - {1'b0, r_n, 2'b00};
                    n_state              = S_CALC;
                end
            end
            S_SUM: begin
                if (w_slot_free) begin
                    w_emit               = 1'b1;
                    n_out.kind           = adbq_pkg::KIND_SUM;
                    n_out.frames_written = r_written;
                    n_out.silence_frames = w_need;
                    n_dropped            = r_dropped + {32'd0, w_need};
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // status reflects the state after this step
        n_out.outstanding_bytes = n_outst;
        n_out.status_full       = (n_count == CW'(QUEUE_DEPTH));
        n_out.status_busy       = (n_count != '0);
        n_out.frames_played     = n_played;
        n_out.frames_dropped    = n_dropped;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_bytes  <= n_bytes;
        r_cons   <= n_cons;
        r_frames <= n_frames;
        r_written <= n_written;
        r_n      <= n_n;
        r_pop    <= n_pop;
        r_rem_lo <= n_rem_lo;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_outst     <= '0;
            r_played    <= '0;
            r_dropped   <= '0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_outst     <= n_outst;
            r_played    <= n_played;
            r_dropped   <= n_dropped;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ----- hdl/audio_dma_buffer_queue.sv -----
// audio_dma_buffer_queue: an enqueue reply passes through the command queue and the result reg.
// A drain is popped from the command queue, then takes one check/apply pair per read segment
// or popped short buffer, then a final check, then the summary.
// The back end takes a new command only when idle; result stalls hold it.
// Synchronous active-low reset: queue empty, counters zero, no result pending.
// Depends on adbq_pkg, adbq_front, adbq_back.
module audio_dma_buffer_queue #(
    parameter int QUEUE_DEPTH = adbq_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command words
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [23:0] i_buf_addr,
    input  logic [17:0] i_buf_bytes,
    input  logic        i_addr_ok,
    input  logic [15:0] i_frames_requested,
    // result words
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic        o_accepted,
    output logic [23:0] o_seg_addr,
    output logic [15:0] o_seg_frames,
    output logic [15:0] o_frames_written,
    output logic [15:0] o_silence_frames,
    output logic [18:0] o_outstanding_bytes,
    output logic        o_status_full,
    output logic        o_status_busy,
    output logic [47:0] o_frames_played,
    output logic [47:0] o_frames_dropped,
    output logic        o_last
);

    // front/back link: classified command words
    logic               w_op_valid;
    logic               w_op_pop;
    adbq_pkg::t_op      w_op;
    adbq_pkg::t_result  w_res;

    // front: accept and classify, buffer up to two words
    adbq_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_buf_addr         (i_buf_addr),
        .i_buf_bytes        (i_buf_bytes),
        .i_addr_ok          (i_addr_ok),
        .i_frames_requested (i_frames_requested),
        .o_op_valid         (w_op_valid),
        .o_op               (w_op),
        .i_op_pop           (w_op_pop)
    );

    // back: buffer queue, counters, drain sequencer, result register
    adbq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .o_op_pop   (w_op_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (w_res)
    );

    // unpack result word onto ports
    assign o_kind              = w_res.kind;
    assign o_accepted          = w_res.accepted;
    assign o_seg_addr          = w_res.seg_addr;
    assign o_seg_frames        = w_res.seg_frames;
    assign o_frames_written    = w_res.frames_written;
    assign o_silence_frames    = w_res.silence_frames;
    assign o_outstanding_bytes = w_res.outstanding_bytes;
    assign o_status_full       = w_res.status_full;
    assign o_status_busy       = w_res.status_busy;
    assign o_frames_played     = w_res.frames_played;
    assign o_frames_dropped    = w_res.frames_dropped;
    assign o_last              = w_res.last;

    // a segment is never the final word and always moves frames
    a_seg_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == adbq_pkg::KIND_SEG) |-> (!o_last && o_seg_frames != '0))
        else $error("segment word with last set or zero frames");

    // replies and summaries close their command
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == adbq_pkg::KIND_ENQ || o_kind == adbq_pkg::KIND_SUM))
        |-> o_last)
        else $error("reply or summary word without last");

    // full queue implies busy
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status_busy || !o_status_full))
        else $error("status full without busy");

endmodule

// ----- bench/tb_audio_dma_buffer_queue.sv -----
// Testbench for audio_dma_buffer_queue: directed and random command words, random
// stalls on both channels, and a scoreboard that predicts every result word.
// Depends on adbq_pkg and the audio_dma_buffer_queue RTL.
`timescale 1ns / 100ps

module tb_audio_dma_buffer_queue;

    localparam logic CMD_SET_BUF  = ~adbq_pkg::CMD_DRAIN;   // enqueue a buffer
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   SETTLE_TICKS = 16;
    localparam int   RANDOM_WORDS = 250;

    // Tracks the buffer queue and counters, and holds the result words still due.
    class dma_reply_tracker;
        logic [23:0] buf_start [adbq_pkg::QUEUE_DEPTH];
        logic [17:0] buf_size  [adbq_pkg::QUEUE_DEPTH];
        logic [17:0] buf_used  [adbq_pkg::QUEUE_DEPTH];
        int          queued;
        logic [47:0] played;
        logic [47:0] dropped;
        adbq_pkg::t_result replies_due [$];
        int          mismatches;
        int          n_commands;
        int          n_drains;
        int          n_segments;
        int          n_refused;
        int          n_checked;

        function new();
            for (int i = 0; i < adbq_pkg::QUEUE_DEPTH; i++) begin
                buf_start[i] = '0;
                buf_size[i]  = '0;
                buf_used[i]  = '0;
            end
            queued     = 0;
            played     = '0;
            dropped    = '0;
            mismatches = 0;
            n_commands = 0;
            n_drains   = 0;
            n_segments = 0;
            n_refused  = 0;
            n_checked  = 0;
        endfunction

        function logic [18:0] bytes_left();
            logic [18:0] sum;
            logic [17:0] part;
            sum = '0;
            for (int i = 0; i < queued; i++) begin
                part = buf_size[i] - buf_used[i];
                sum  = sum + 19'(part);
            end
            return sum;
        endfunction

        // status fields reflect the state after the step
        function void push_reply(logic [1:0] kind, logic acc, logic [23:0] saddr,
                                 logic [15:0] sframes, logic [15:0] fw,
                                 logic [15:0] sil, logic fin);
            adbq_pkg::t_result r;
            r                   = '0;
            r.kind              = kind;
            r.accepted          = acc;
            r.seg_addr          = saddr;
            r.seg_frames        = sframes;
            r.frames_written    = fw;
            r.silence_frames    = sil;
            r.outstanding_bytes = bytes_left();
            r.status_full       = (queued >= adbq_pkg::QUEUE_DEPTH);
            r.status_busy       = (queued >= 1);
            r.frames_played     = played;
            r.frames_dropped    = dropped;
            r.last              = fin;
            replies_due.push_back(r);
        endfunction

        function void pop_head();
            for (int i = 0; i + 1 < adbq_pkg::QUEUE_DEPTH; i++) begin
                buf_start[i] = buf_start[i + 1];
                buf_size[i]  = buf_size[i + 1];
                buf_used[i]  = buf_used[i + 1];
            end
            if (queued > 0) queued--;
        endfunction

        function void take_command(logic cmd, logic [23:0] addr, logic [17:0] nbytes,
                                   logic ok, logic [15:0] want);
            int          written;
            int          avail;
            int          n;
            logic [17:0] rest;
            logic [23:0] saddr;
            n_commands++;
            if (cmd == CMD_SET_BUF) begin
                if (queued < adbq_pkg::QUEUE_DEPTH && ok) begin
                    buf_start[queued] = addr;
                    buf_size[queued]  = nbytes;
                    buf_used[queued]  = '0;
                    queued++;
                    push_reply(adbq_pkg::KIND_ENQ, 1'b1, '0, '0, '0, '0, 1'b1);
                end else begin
                    n_refused++;
                    push_reply(adbq_pkg::KIND_ENQ, 1'b0, '0, '0, '0, '0, 1'b1);
                end
            end else begin
                n_drains++;
                written = 0;
                while (written < int'(want) && queued > 0) begin
                    rest  = buf_size[0] - buf_used[0];
                    avail = int'(rest) / 4;
                    if (avail == 0) begin
                        // short head: dropped only once the drain reaches it
                        pop_head();
                    end else begin
                        n = int'(want) - written;
                        if (avail < n) n = avail;
                        saddr       = buf_start[0] + 24'(buf_used[0]);
                        buf_used[0] = buf_used[0] + 18'(n * 4);
                        written     = written + n;
                        played      = played + 48'(n);
                        n_segments++;
                        push_reply(adbq_pkg::KIND_SEG, 1'b0, saddr, 16'(n), '0, '0, 1'b0);
                    end
                end
                // underrun is filled with silence
                dropped = dropped + 48'(int'(want) - written);
                push_reply(adbq_pkg::KIND_SUM, 1'b0, '0, '0, 16'(written),
                           16'(int'(want) - written), 1'b1);
            end
        endfunction

        function void field_check(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_reply(adbq_pkg::t_result got);
            adbq_pkg::t_result want;
            if (replies_due.size() == 0) begin
                $error("result word with nothing expected: kind %0d", got.kind);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                n_checked++;
                field_check("kind", 48'(want.kind), 48'(got.kind));
                field_check("accepted", 48'(want.accepted), 48'(got.accepted));
                field_check("seg_addr", 48'(want.seg_addr), 48'(got.seg_addr));
                field_check("seg_frames", 48'(want.seg_frames), 48'(got.seg_frames));
                field_check("frames_written", 48'(want.frames_written),
                            48'(got.frames_written));
                field_check("silence_frames", 48'(want.silence_frames),
                            48'(got.silence_frames));
                field_check("outstanding_bytes", 48'(want.outstanding_bytes),
                            48'(got.outstanding_bytes));
                field_check("status_full", 48'(want.status_full), 48'(got.status_full));
                field_check("status_busy", 48'(want.status_busy), 48'(got.status_busy));
                field_check("frames_played", want.frames_played, got.frames_played);
                field_check("frames_dropped", want.frames_dropped, got.frames_dropped);
                field_check("last", 48'(want.last), 48'(got.last));
            end
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_cmd = CMD_SET_BUF;
    logic [23:0] i_buf_addr = '0;
    logic [17:0] i_buf_bytes = '0;
    logic        i_addr_ok = 1'b0;
    logic [15:0] i_frames_requested = '0;
    logic        i_ready = 1'b0;

    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic        o_accepted;
    logic [23:0] o_seg_addr;
    logic [15:0] o_seg_frames;
    logic [15:0] o_frames_written;
    logic [15:0] o_silence_frames;
    logic [18:0] o_outstanding_bytes;
    logic        o_status_full;
    logic        o_status_busy;
    logic [47:0] o_frames_played;
    logic [47:0] o_frames_dropped;
    logic        o_last;

    adbq_pkg::t_result seen;
    dma_reply_tracker  book = new();
    int                idle_pct = 0;     // chance in percent of starting an idle burst
    int                stall_left = 0;
    int                cycle_count = 0;

    always #2 i_clk = ~i_clk;

    audio_dma_buffer_queue DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_buf_addr         (i_buf_addr),
        .i_buf_bytes        (i_buf_bytes),
        .i_addr_ok          (i_addr_ok),
        .i_frames_requested (i_frames_requested),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_accepted         (o_accepted),
        .o_seg_addr         (o_seg_addr),
        .o_seg_frames       (o_seg_frames),
        .o_frames_written   (o_frames_written),
        .o_silence_frames   (o_silence_frames),
        .o_outstanding_bytes(o_outstanding_bytes),
        .o_status_full      (o_status_full),
        .o_status_busy      (o_status_busy),
        .o_frames_played    (o_frames_played),
        .o_frames_dropped   (o_frames_dropped),
        .o_last             (o_last)
    );

    assign seen = {o_kind, o_accepted, o_seg_addr, o_seg_frames, o_frames_written,
                   o_silence_frames, o_outstanding_bytes, o_status_full, o_status_busy,
                   o_frames_played, o_frames_dropped, o_last};

    // Result side: check each word taken at this edge, then pick ready for the
    // next cycle. Stalls come in bursts of random length.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) book.match_reply(seen);
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 19) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result words still due",
                     cycle_count, book.replies_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one command word and hold it until the block takes it. Valid is
    // only lowered when an idle burst follows, so it gets one update per edge.
    task automatic send_word(logic cmd, logic [23:0] addr, logic [17:0] nbytes,
                             logic ok, logic [15:0] want);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_cmd              <= cmd;
        i_buf_addr         <= addr;
        i_buf_bytes        <= nbytes;
        i_addr_ok          <= ok;
        i_frames_requested <= want;
        do @(posedge i_clk); while (!o_ready);
        book.take_command(cmd, addr, nbytes, ok, want);
    endtask

    task automatic set_buffer(logic [23:0] addr, logic [17:0] nbytes, logic ok);
        send_word(CMD_SET_BUF, addr, nbytes, ok, 16'($urandom()));
    endtask

    task automatic drain(logic [15:0] want);
        send_word(adbq_pkg::CMD_DRAIN, 24'($urandom()), 18'($urandom()), 1'($urandom()),
                  want);
    endtask

    // One random word: mostly small buffers and short drains so that buffers
    // run dry, straddle drains and leave short tails; the rest spans full range.
    task automatic random_word();
        int          pick;
        int          sz;
        logic [17:0] nbytes;
        logic [15:0] want;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            sz = $urandom_range(0, 9);
            if (sz == 0)
                nbytes = 18'($urandom_range(0, 3));
            else if (sz < 7)
                nbytes = 18'(4 * $urandom_range(1, 16) + $urandom_range(0, 3) * (sz & 1));
            else
                nbytes = 18'($urandom());
            set_buffer(24'($urandom()), nbytes, $urandom_range(0, 9) != 0);
        end else begin
            sz = $urandom_range(0, 99);
            if (sz < 8)
                want = '0;
            else if (sz < 68)
                want = 16'($urandom_range(1, 20));
            else if (sz < 85)
                want = 16'($urandom_range(21, 200));
            else
                want = 16'($urandom());
            drain(want);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;

        // directed words
        drain(16'd0);                              // zero-frame drain, empty queue
        drain(16'd5);                              // underrun on empty queue
        set_buffer(24'hABCDEF, 18'd100, 1'b0);     // bad address
        set_buffer(24'hFFFFFF, 18'h3FFFF, 1'b0);   // bad address, extreme fields
        set_buffer(24'hFFFFFF, 18'h3FFFF, 1'b1);
        set_buffer(24'h000000, 18'd0, 1'b1);
        set_buffer(24'h123456, 18'd40, 1'b1);      // queue full
        drain(16'd0);                              // nothing popped
        drain(16'hFFFF);                           // head leaves a 3 byte tail
        drain(16'd1);                              // pops tail and empty buffer
        set_buffer(24'hFFFFF0, 18'd100, 1'b1);
        set_buffer(24'h000100, 18'd3, 1'b1);
        drain(16'd10);
        drain(16'd30);                             // address wraps past 2^24
        set_buffer(24'h00AA00, 18'd8, 1'b1);
        set_buffer(24'h005555, 18'd13, 1'b1);
        drain(16'd5);                              // two segments plus summary
        set_buffer(24'h7F0000, 18'd2, 1'b1);
        drain(16'hFFFF);                           // short buffers only, full silence
        drain(16'h8000);
        set_buffer(24'h800000, 18'h20000, 1'b1);
        set_buffer(24'h7FFFFF, 18'h1FFFF, 1'b1);
        drain(16'h7FFF);                           // served from the first buffer alone
        drain(16'd16);

        // random words, idling varied by phase, none toward the end
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k < 100)      idle_pct = 30;
            else if (k < 160) idle_pct = 0;
            else if (k < 210) idle_pct = 10;
            else              idle_pct = 0;
            random_word();
        end
        i_valid <= 1'b0;

        while (book.replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Ran %0d commands: %0d drains, %0d refused enqueues",
                 book.n_commands, book.n_drains, book.n_refused);
        $display("Checked %0d result words, %0d of them read segments",
                 book.n_checked, book.n_segments);
        if (book.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/adbq_pkg.sv
hdl/adbq_front.sv
hdl/adbq_back.sv
hdl/audio_dma_buffer_queue.sv
bench/tb_audio_dma_buffer_queue.sv
